/* sv/point_moving_average_top_defines.svh */
// Assertion macros shared by the point moving average block.
`ifndef POINT_MOVING_AVERAGE_TOP_DEFINES_SVH
`define POINT_MOVING_AVERAGE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define PMA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point moving average: same-cycle check failed");

`define PMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point moving average: next-cycle check failed");

`else

`define PMA_ASSERT_IMPL(label, ante, cons)

`define PMA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/pma_pkg.sv */
`timescale 1ns / 1ps

package pma_pkg;

  localparam int WINDOW_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_START    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_END      = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd4;

  typedef struct packed {
    logic latch;
    logic restart;
    logic push_rd;
    logic push_wr;
    logic cnt_load;
    logic cnt_dec;
    logic div_start;
    logic out_load;
    logic out_last;
    logic close;
  } pma_cmd_t;

  typedef struct packed {
    logic curve_open;
    logic first;
    logic last;
    logic hold_start;
    logic hold_end;
    logic full;
    logic cnt_one;
    logic div_busy;
    logic out_free;
  } pma_status_t;

endpackage

/* sv/pma_in_if.sv */
`timescale 1ns / 1ps

interface pma_in_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         curve_first;
  logic                         curve_last;

  modport source (output valid, point_x, point_y, curve_first, curve_last, input ready);
  modport sink   (input valid, point_x, point_y, curve_first, curve_last, output ready);
endinterface

/* sv/pma_out_if.sv */
`timescale 1ns / 1ps

interface pma_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] avg_x;
  logic signed [COORD_BITS-1:0] avg_y;
  logic                         run_last;

  modport source (output valid, avg_x, avg_y, run_last, input ready);
  modport sink   (input valid, avg_x, avg_y, run_last, output ready);
endinterface

/* sv/pma_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divides the magnitude and
// restores the sign afterwards, so the quotient truncates toward zero.
module pma_div #(
  parameter int SUM_W = 38,
  parameter int DIV_W = 6,
  parameter int Q_W   = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    busy,
  output logic [Q_W-1:0]          quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] q_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] d_r;
  logic             neg_r;

  logic [SUM_W-1:0] mag;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             q_bit;
  logic [DIV_W-1:0] rem_nxt;

  always_comb begin
    mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    rem_sh  = {rem_r, q_r[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, d_r};
    q_bit   = (rem_sh >= {1'b0, d_r});
    rem_nxt = q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(SUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mag;
      rem_r <= '0;
      d_r   <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (Q_W'(0) - q_r[Q_W-1:0]) : q_r[Q_W-1:0];

endmodule

/* sv/pma_datapath.sv */
`timescale 1ns / 1ps

module pma_datapath import pma_pkg::*; #(
  parameter int WINDOW_MAX = 32,
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pma_cmd_t                     cmd,
  output pma_status_t                  sts,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_curve_first,
  input  logic                         in_curve_last,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_avg_x,
  output logic signed [COORD_BITS-1:0] out_avg_y,
  output logic                         out_run_last
);

  localparam int EW    = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = COORD_BITS + EW;
  localparam int RESET_EFF = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : int'(WINDOW_RESET);

  function automatic logic [EW-1:0] eff_of(input logic [WINDOW_W-1:0] w);
    logic [EW-1:0] e;
    if (w == '0) begin
      e = EW'(1);
    end else if (w > WINDOW_W'(WINDOW_MAX)) begin
      e = EW'(WINDOW_MAX);
    end else begin
      e = EW'(w);
    end
    return e;
  endfunction

  // Configuration and filter state.
  logic [WINDOW_W-1:0]     window_r;
  logic                    hold_start_r;
  logic                    hold_end_r;
  logic signed [SUM_W-1:0] sum_x_r;
  logic signed [SUM_W-1:0] sum_y_r;
  logic [PTR_W-1:0]        pos_r;
  logic [EW-1:0]           primed_r;
  logic                    open_r;
  logic [EW-1:0]           cnt_r;
  logic                    out_valid_r;

  // Payload registers.
  logic signed [COORD_BITS-1:0] pt_x_r;
  logic signed [COORD_BITS-1:0] pt_y_r;
  logic                         first_r;
  logic                         last_r;
  logic signed [COORD_BITS-1:0] rd_x_r;
  logic signed [COORD_BITS-1:0] rd_y_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  logic                         out_last_r;

  logic signed [COORD_BITS-1:0] ring_x [WINDOW_MAX];
  logic signed [COORD_BITS-1:0] ring_y [WINDOW_MAX];

  logic [EW-1:0]           eff_w;
  logic [EW-1:0]           cfg_eff;
  logic [PTR_W-1:0]        pos_inc;
  logic                    full;
  logic signed [SUM_W-1:0] sum_x_nxt;
  logic signed [SUM_W-1:0] sum_y_nxt;
  logic                    busy_x;
  logic                    busy_y;
  logic [COORD_BITS-1:0]   quo_x;
  logic [COORD_BITS-1:0]   quo_y;

  always_comb begin
    eff_w   = eff_of(window_r);
    cfg_eff = eff_of(cfg_data[WINDOW_W-1:0]);
    pos_inc = (EW'(pos_r) + EW'(1) == eff_w) ? '0 : pos_r + PTR_W'(1);
    full    = (primed_r >= eff_w);
    // The slot being overwritten leaves the sum only once the ring is full.
    sum_x_nxt = sum_x_r + SUM_W'(pt_x_r) - (full ? SUM_W'(rd_x_r) : SUM_W'(0));
    sum_y_nxt = sum_y_r + SUM_W'(pt_y_r) - (full ? SUM_W'(rd_y_r) : SUM_W'(0));
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      ring_x[pos_r] <= pt_x_r;
      ring_y[pos_r] <= pt_y_r;
    end
    if (cmd.push_rd) begin
      rd_x_r <= ring_x[pos_inc];
      rd_y_r <= ring_y[pos_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RESET;
      hold_start_r <= 1'b0;
      hold_end_r   <= 1'b0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      pos_r        <= PTR_W'(RESET_EFF - 1);
      primed_r     <= '0;
      open_r       <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: begin
            window_r <= cfg_data[WINDOW_W-1:0];
            sum_x_r  <= '0;
            sum_y_r  <= '0;
            pos_r    <= PTR_W'(cfg_eff - EW'(1));
            primed_r <= '0;
            open_r   <= 1'b0;
          end
          CFG_HOLD_START: hold_start_r <= cfg_data[0];
          CFG_HOLD_END:   hold_end_r   <= cfg_data[0];
          default: ;
        endcase
      end else begin
        if (cmd.restart) begin
          sum_x_r  <= '0;
          sum_y_r  <= '0;
          pos_r    <= PTR_W'(eff_w - EW'(1));
          primed_r <= '0;
          open_r   <= 1'b1;
        end
        if (cmd.push_rd) begin
          pos_r <= pos_inc;
        end
        if (cmd.push_wr) begin
          sum_x_r <= sum_x_nxt;
          sum_y_r <= sum_y_nxt;
          if (!full) begin
            primed_r <= primed_r + EW'(1);
          end
        end
        if (cmd.close) begin
          open_r <= 1'b0;
        end
      end
      if (cmd.cnt_load) begin
        cnt_r <= eff_w;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - EW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pt_x_r  <= in_point_x;
      pt_y_r  <= in_point_y;
      first_r <= in_curve_first;
      last_r  <= in_curve_last;
    end
    if (cmd.out_load) begin
      out_x_r    <= quo_x;
      out_y_r    <= quo_y;
      out_last_r <= cmd.out_last;
    end
  end

  pma_div #(.SUM_W(SUM_W), .DIV_W(EW), .Q_W(COORD_BITS)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_x_r),
    .divisor  (eff_w),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  pma_div #(.SUM_W(SUM_W), .DIV_W(EW), .Q_W(COORD_BITS)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_y_r),
    .divisor  (eff_w),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  always_comb begin
    sts.curve_open = open_r;
    sts.first      = first_r;
    sts.last       = last_r;
    sts.hold_start = hold_start_r;
    sts.hold_end   = hold_end_r;
    sts.full       = full;
    sts.cnt_one    = (cnt_r == EW'(1));
    sts.div_busy   = busy_x || busy_y;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_avg_x    = out_x_r;
  assign out_avg_y    = out_y_r;
  assign out_run_last = out_last_r;

endmodule

/* sv/pma_ctrl.sv */
`timescale 1ns / 1ps

module pma_ctrl import pma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pma_status_t sts,
  output pma_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PRE_RD,
    S_PRE_WR,
    S_MAIN_RD,
    S_MAIN_WR,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FL_RD,
    S_FL_WR,
    S_TAIL
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   gave_r, gave_nxt;
  logic   flush_r, flush_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    gave_nxt  = gave_r;
    flush_nxt = flush_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.first || !sts.curve_open) begin
          cmd.restart = 1'b1;
          if (sts.hold_start) begin
            cmd.cnt_load = 1'b1;
            state_nxt    = S_PRE_RD;
          end else begin
            state_nxt = S_MAIN_RD;
          end
        end else begin
          state_nxt = S_MAIN_RD;
        end
      end
      S_PRE_RD: begin
        cmd.push_rd = 1'b1;
        state_nxt   = S_PRE_WR;
      end
      S_PRE_WR: begin
        cmd.push_wr = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_nxt   = sts.cnt_one ? S_MAIN_RD : S_PRE_RD;
      end
      S_MAIN_RD: begin
        // A result follows only if the ring was already full before this push.
        gave_nxt    = sts.full;
        flush_nxt   = 1'b0;
        cmd.push_rd = 1'b1;
        state_nxt   = S_MAIN_WR;
      end
      S_MAIN_WR: begin
        cmd.push_wr = 1'b1;
        state_nxt   = gave_r ? S_DIV_GO : S_TAIL;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          if (flush_r) begin
            cmd.out_last = sts.cnt_one;
            cmd.cnt_dec  = 1'b1;
            state_nxt    = sts.cnt_one ? S_TAIL : S_FL_RD;
          end else if (sts.last && sts.hold_end) begin
            cmd.out_last = 1'b0;
            cmd.cnt_load = 1'b1;
            flush_nxt    = 1'b1;
            state_nxt    = S_FL_RD;
          end else begin
            cmd.out_last = 1'b1;
            state_nxt    = S_TAIL;
          end
        end
      end
      S_FL_RD: begin
        cmd.push_rd = 1'b1;
        state_nxt   = S_FL_WR;
      end
      S_FL_WR: begin
        cmd.push_wr = 1'b1;
        state_nxt   = S_DIV_GO;
      end
      S_TAIL: begin
        cmd.close = sts.last;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
      gave_r     <= 1'b0;
      flush_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
      gave_r     <= gave_nxt;
      flush_r    <= flush_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

/* sv/point_moving_average_top.sv */
`timescale 1ns / 1ps

// Boxcar moving average over a stream of Q16.16 points, one curve at a time.
// An item without a result passes through the start, ring read, ring write
// and tail states. A bit-serial divider divides the running sums by the
// window length. An item's own result adds a divider start and a wait for
// both dividers and a free output register. With hold_end the last item of
// a curve, if it gives a result, adds one flush result per window entry,
// each needing a ring read, a ring write and a division. Pre-filling the
// ring at a curve start with hold_start writes every window entry, each
// ring write needing a read of the old entry first.
// The next item is accepted once all results of the current one are in the
// output register; a result may still be waiting there for its consumer.
`include "point_moving_average_top_defines.svh"

module point_moving_average_top import pma_pkg::*; #(
  parameter int WINDOW_MAX = 32,
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pma_in_if.sink                in_ch,
  pma_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pma_cmd_t    cmd;
  pma_status_t sts;
  logic        in_ready;

  pma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pma_datapath #(.WINDOW_MAX(WINDOW_MAX), .COORD_BITS(COORD_BITS)) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_point_x     (in_ch.point_x),
    .in_point_y     (in_ch.point_y),
    .in_curve_first (in_ch.curve_first),
    .in_curve_last  (in_ch.curve_last),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_avg_x      (out_ch.avg_x),
    .out_avg_y      (out_ch.avg_y),
    .out_run_last   (out_ch.run_last)
  );

  assign in_ch.ready = in_ready;

  // A result is only loaded when the output slot is empty or being drained.
  `PMA_ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, sts.out_free)
  // A new item is never taken while a division is still running.
  `PMA_ASSERT_IMPL(a_idle_when_ready, in_ready, !sts.div_busy)
  // The dividers start on the cycle after they are told to.
  `PMA_ASSERT_NEXT(a_div_starts, cmd.div_start, sts.div_busy)

endmodule
